// ===== rtl/core/lcalc_pkg.sv =====
// Shared types, constants and segment tables for the lux calculator.
// No dependencies; the testbench and every RTL file but the checker refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lcalc_pkg;

  // Field and datapath widths
  localparam int COUNT_W   = 16;
  localparam int SCALE_W   = 19;
  localparam int CHAN_FRAC = 10;
  localparam int PROD_W    = COUNT_W + SCALE_W;   // count * scale
  localparam int CHAN_W    = PROD_W - CHAN_FRAC;  // scaled channel, 25 bits
  localparam int Q_W       = 12;                  // saturated quotient bits
  localparam int REM_W     = CHAN_W + Q_W;        // divider remainder
  localparam int RATIO_W   = Q_W;
  localparam int COEF_W    = 10;
  localparam int MUL_W     = CHAN_W + COEF_W;
  localparam int LUX_FRAC  = 14;
  localparam int LUX_W     = 21;
  localparam int SEG_N     = 7;                   // breakpoints before the catch-all

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PKG   = 2'd2;

  // Integration time codes (the unused code behaves as the long setting)
  localparam logic [1:0] ITIME_SHORT = 2'd0;
  localparam logic [1:0] ITIME_MID   = 2'd1;

  localparam logic [SCALE_W-1:0] TSCALE_SHORT = 19'h07517;
  localparam logic [SCALE_W-1:0] TSCALE_MID   = 19'h00fe7;
  localparam logic [SCALE_W-1:0] TSCALE_UNITY = 19'h00400;

  localparam logic PKG_T  = 1'b0;
  localparam logic PKG_CS = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] ch1;
    logic [CHAN_W-1:0] ch0;
  } chan_pair_t;

  typedef struct packed {
    chan_pair_t     chan;
    logic [Q_W-1:0] quot;
  } div_out_t;

  typedef struct packed {
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] slope;
  } seg_t;

  typedef logic [RATIO_W-1:0] brk_arr_t  [SEG_N];
  typedef logic [COEF_W-1:0]  coef_arr_t [SEG_N];

  localparam brk_arr_t BRK_T = '{12'h040, 12'h080, 12'h0c0, 12'h100,
                                 12'h138, 12'h19a, 12'h29a};
  localparam coef_arr_t OFF_T = '{10'h1f2, 10'h214, 10'h23f, 10'h270,
                                  10'h16f, 10'h0d2, 10'h018};
  localparam coef_arr_t SLOPE_T = '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe,
                                    10'h1fc, 10'h0fb, 10'h012};
  localparam brk_arr_t BRK_CS = '{12'h043, 12'h085, 12'h0c8, 12'h10a,
                                  12'h14d, 12'h19a, 12'h29a};
  localparam coef_arr_t OFF_CS = '{10'h204, 10'h228, 10'h253, 10'h282,
                                   10'h177, 10'h101, 10'h037};
  localparam coef_arr_t SLOPE_CS = '{10'h1ad, 10'h2c1, 10'h363, 10'h3df,
                                     10'h1dd, 10'h127, 10'h02b};

  // First breakpoint at or above the ratio wins; above the last, zero coefficients
  function automatic seg_t seg_lookup(input logic pkg_kind, input logic [RATIO_W-1:0] ratio);
    seg_t res;
    res = '0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (pkg_kind == PKG_CS) begin
        if (ratio <= BRK_CS[i]) begin
          res.off   = OFF_CS[i];
          res.slope = SLOPE_CS[i];
        end
      end else begin
        if (ratio <= BRK_T[i]) begin
          res.off   = OFF_T[i];
          res.slope = SLOPE_T[i];
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcalc_scale.sv =====
// Front stage: scales both raw counts for integration time and gain.
// Depends on lcalc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcalc_scale (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lcalc_pkg::COUNT_W-1:0]  bb,
  input  wire logic [lcalc_pkg::COUNT_W-1:0]  ir,
  input  wire logic [1:0]                     itime,
  input  wire logic                           high_gain,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output lcalc_pkg::chan_pair_t               out_chan
);

  logic [lcalc_pkg::SCALE_W-1:0] scale_base;
  logic [lcalc_pkg::SCALE_W-1:0] scale;
  logic [lcalc_pkg::PROD_W-1:0]  prod0;
  logic [lcalc_pkg::PROD_W-1:0]  prod1;

  // Scale factor, 10 fraction bits; low gain adds a further x16
  always_comb begin
    case (itime)
      lcalc_pkg::ITIME_SHORT: scale_base = lcalc_pkg::TSCALE_SHORT;
      lcalc_pkg::ITIME_MID:   scale_base = lcalc_pkg::TSCALE_MID;
      default:                scale_base = lcalc_pkg::TSCALE_UNITY;
    endcase
    scale = high_gain ? scale_base : (scale_base << 4);
    prod0 = lcalc_pkg::PROD_W'(bb) * lcalc_pkg::PROD_W'(scale);
    prod1 = lcalc_pkg::PROD_W'(ir) * lcalc_pkg::PROD_W'(scale);
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_chan.ch0 <= prod0[lcalc_pkg::PROD_W-1:lcalc_pkg::CHAN_FRAC];
      out_chan.ch1 <= prod1[lcalc_pkg::PROD_W-1:lcalc_pkg::CHAN_FRAC];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcalc_div.sv =====
// Pipelined restoring divider: (ch1 << 10) / ch0, one quotient bit per stage,
// saturated to 12 bits, zero when ch0 is zero. Depends on lcalc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcalc_div (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lcalc_pkg::chan_pair_t in_chan,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lcalc_pkg::div_out_t        out_data
);

  localparam int NST = lcalc_pkg::Q_W;

  typedef struct packed {
    logic sat;   // quotient would not fit: force all ones
    logic zero;  // divisor zero: force zero
  } div_flags_t;

  // Index 0 is the input side, index k+1 the register after stage k
  logic                             v    [NST+1];
  logic                             rdy  [NST+1];
  lcalc_pkg::chan_pair_t            chan [NST+1];
  logic [lcalc_pkg::REM_W-1:0]      rem  [NST+1];
  logic [lcalc_pkg::Q_W-1:0]        quot [NST+1];
  div_flags_t                       flg  [NST+1];

  assign v[0]    = in_valid;
  assign chan[0] = in_chan;
  assign rem[0]  = lcalc_pkg::REM_W'({in_chan.ch1, 10'd0});
  assign quot[0] = '0;
  assign flg[0]  = '0;
  assign in_ready = rdy[0];
  assign rdy[NST] = out_ready;

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_stage
      logic [lcalc_pkg::REM_W-1:0] d_sh;
      logic                        ge;
      div_flags_t                  flg_n;

      // Trial subtract of the divisor at this quotient weight
      always_comb begin
        d_sh = lcalc_pkg::REM_W'(chan[k].ch0) << (NST - 1 - k);
        ge   = rem[k] >= d_sh;
        if (k == 0) begin
          flg_n.zero = chan[k].ch0 == '0;
          flg_n.sat  = (lcalc_pkg::REM_W'(chan[k].ch1) >=
                        (lcalc_pkg::REM_W'(chan[k].ch0) << 2));
        end else begin
          flg_n = flg[k];
        end
      end

      assign rdy[k] = !v[k+1] || rdy[k+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k+1] <= 1'b0;
        end else if (rdy[k]) begin
          v[k+1] <= v[k];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && v[k]) begin
          chan[k+1] <= chan[k];
          flg[k+1]  <= flg_n;
          rem[k+1]  <= ge ? (rem[k] - d_sh) : rem[k];
          quot[k+1] <= quot[k] | (lcalc_pkg::Q_W'(ge) << (NST - 1 - k));
        end
      end
    end
  endgenerate

  // Apply the special cases on the way out
  always_comb begin
    out_valid     = v[NST];
    out_data.chan = chan[NST];
    if (flg[NST].zero) begin
      out_data.quot = '0;
    end else if (flg[NST].sat) begin
      out_data.quot = '1;
    end else begin
      out_data.quot = quot[NST];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcalc_mac.sv =====
// Back end: ratio rounding and segment lookup, the two products, then
// clamped difference and rounding to whole lux. Depends on lcalc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcalc_mac (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lcalc_pkg::div_out_t          in_data,
  input  wire logic                         pkg_kind,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lcalc_pkg::LUX_W-1:0]       lux
);

  // Stage A: coefficients
  logic                       va;
  lcalc_pkg::chan_pair_t      chan_a;
  lcalc_pkg::seg_t            seg_a;
  // Stage B: products
  logic                       vb;
  logic [lcalc_pkg::MUL_W-1:0] pos_b;
  logic [lcalc_pkg::MUL_W-1:0] neg_b;

  logic                         rdy_a, rdy_b, rdy_c;
  logic [lcalc_pkg::Q_W:0]      ratio_sum;
  logic [lcalc_pkg::RATIO_W-1:0] ratio;
  lcalc_pkg::seg_t              seg;
  logic [lcalc_pkg::MUL_W-1:0]  diff;
  logic [lcalc_pkg::MUL_W:0]    lux_sum;

  assign rdy_c    = !out_valid || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  // Round the quotient from 10 to 9 fraction bits and pick the segment
  always_comb begin
    ratio_sum = (lcalc_pkg::Q_W + 1)'(in_data.quot) + 1'b1;
    ratio     = ratio_sum[lcalc_pkg::Q_W:1];
    seg       = lcalc_pkg::seg_lookup(pkg_kind, ratio);
  end

  // Clamp at zero, add half an lsb, drop the fraction bits
  always_comb begin
    diff    = (pos_b > neg_b) ? (pos_b - neg_b) : '0;
    lux_sum = (lcalc_pkg::MUL_W + 1)'(diff) +
              ((lcalc_pkg::MUL_W + 1)'(1) << (lcalc_pkg::LUX_FRAC - 1));
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) out_valid <= vb;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      chan_a <= in_data.chan;
      seg_a  <= seg;
    end
    if (rdy_b && va) begin
      pos_b <= lcalc_pkg::MUL_W'(chan_a.ch0) * lcalc_pkg::MUL_W'(seg_a.off);
      neg_b <= lcalc_pkg::MUL_W'(chan_a.ch1) * lcalc_pkg::MUL_W'(seg_a.slope);
    end
    if (rdy_c && vb) begin
      lux <= lux_sum[lcalc_pkg::LUX_FRAC + lcalc_pkg::LUX_W - 1:lcalc_pkg::LUX_FRAC];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ambient_light_lux_calc_top.sv =====
// Top level of the lux calculator: configuration registers and the pipeline.
// Depends on lcalc_pkg, lcalc_scale, lcalc_div and lcalc_mac.
//
//   channel   direction  request moved                       accepted when
//   s_axis    in         broadband_count, infrared_count     s_tvalid && s_tready
//   m_axis    out        lux_value                           m_tvalid && m_tready
//   cfg       in         register index and data             cfg_we
//
// One request enters per cycle while no m_axis stall has backed up to s_tready;
// the pipeline has 1 scaling stage, 12 divider stages, one per quotient bit, and 3 back-end stages.
// rst is synchronous and clears the valid bits and the configuration registers.
// Each stage holds while the stage after it is full and stalled, so a stall on
// m_axis fills bubbles first and only then lowers s_tready.
`timescale 1ns / 1ps
`default_nettype none

module ambient_light_lux_calc_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [31:0]                       s_tdata,   // broadband_count, infrared_count
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [23:0]                            m_tdata,   // lux_value, zero pad
  input  wire logic                              cfg_we,
  input  wire logic [lcalc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lcalc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [1:0] itime;
  logic       high_gain;
  logic       pkg_kind;

  logic                          sc_valid, sc_ready;
  lcalc_pkg::chan_pair_t         sc_chan;
  logic                          dv_valid, dv_ready;
  lcalc_pkg::div_out_t           dv_data;
  logic [lcalc_pkg::LUX_W-1:0]   lux;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      itime     <= lcalc_pkg::ITIME_SHORT;
      high_gain <= 1'b0;
      pkg_kind  <= lcalc_pkg::PKG_T;
    end else if (cfg_we) begin
      case (cfg_index)
        lcalc_pkg::CFG_ITIME: itime     <= cfg_data;
        lcalc_pkg::CFG_GAIN:  high_gain <= cfg_data[0];
        lcalc_pkg::CFG_PKG:   pkg_kind  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lcalc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .bb        (s_tdata[15:0]),
    .ir        (s_tdata[31:16]),
    .itime     (itime),
    .high_gain (high_gain),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_chan  (sc_chan)
  );

  lcalc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_chan   (sc_chan),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  lcalc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .pkg_kind  (pkg_kind),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .lux       (lux)
  );

  assign m_tdata = {3'b000, lux};

endmodule

`default_nettype wire

// ===== rtl/core/lcalc_checker.sv =====
// Port-level checks for the lux calculator, bound to the top level.
// Depends on ambient_light_lux_calc_top.
`timescale 1ns / 1ps
`default_nettype none

module lcalc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Input back-pressure only when the pipeline is full and the output stalled
  a_bp_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output stall");

  // Lux never exceeds 21 bits
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:21] == 3'b000)
    else $error("pad bits set in result");

endmodule

bind ambient_light_lux_calc_top lcalc_checker u_lcalc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/tb_ambient_light_lux_calc_top.sv =====
// Self-checking testbench for the lux calculator: streams count pairs, predicts each lux value
// and checks it on m_axis under random stalls on both sides. Depends on lcalc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_ambient_light_lux_calc_top;

  localparam int  LIMIT      = 200000;
  localparam int  PHASE_N    = 7;
  localparam int  RAND_ITEMS = 68;
  localparam int  SETTLE     = 40;
  localparam logic [lcalc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Breakpoints and coefficients per package, catch-all row implied past the end
  localparam int BRK_T_TB[7]    = '{'h040, 'h080, 'h0c0, 'h100, 'h138, 'h19a, 'h29a};
  localparam int OFF_T_TB[7]    = '{'h1f2, 'h214, 'h23f, 'h270, 'h16f, 'h0d2, 'h018};
  localparam int SLP_T_TB[7]    = '{'h1be, 'h2d1, 'h37b, 'h3fe, 'h1fc, 'h0fb, 'h012};
  localparam int BRK_CS_TB[7]   = '{'h043, 'h085, 'h0c8, 'h10a, 'h14d, 'h19a, 'h29a};
  localparam int OFF_CS_TB[7]   = '{'h204, 'h228, 'h253, 'h282, 'h177, 'h101, 'h037};
  localparam int SLP_CS_TB[7]   = '{'h1ad, 'h2c1, 'h363, 'h3df, 'h1dd, 'h127, 'h02b};

  // Register settings per phase; gain data is raw so that masking is exercised
  localparam logic [1:0] PH_ITIME[PHASE_N] = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1};
  localparam logic [1:0] PH_GAIN[PHASE_N]  = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0};
  localparam logic [1:0] PH_PKG[PHASE_N]   = '{2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd0};

  typedef struct packed {
    logic [15:0] infrared;
    logic [15:0] broadband;
  } count_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // broadband_count, infrared_count
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // lux_value, zero pad
  logic        cfg_we = 1'b0;
  logic [lcalc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lcalc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Mirror of the configuration registers
  logic [1:0] itime_sel = lcalc_pkg::ITIME_SHORT;
  logic       gain_hi   = 1'b0;
  logic       pkg_kind  = lcalc_pkg::PKG_T;

  count_pair_t  pair_queue[$];
  logic [20:0]  lux_expected[$];
  int           err_cnt   = 0;
  int           cycle_cnt = 0;
  logic         steady    = 1'b0;

  ambient_light_lux_calc_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Lux from one count pair under the current register settings
  function automatic logic [20:0] lux_predict(count_pair_t p);
    logic [63:0] scale, ch0, ch1, ratio, pos, neg, diff;
    logic [63:0] off, slope;
    off   = 0;
    slope = 0;
    if (itime_sel == lcalc_pkg::ITIME_SHORT)    scale = 64'(lcalc_pkg::TSCALE_SHORT);
    else if (itime_sel == lcalc_pkg::ITIME_MID) scale = 64'(lcalc_pkg::TSCALE_MID);
    else                                        scale = 64'd1024;
    if (!gain_hi) scale = scale << 4;
    ch0 = (64'(p.broadband) * scale) >> 10;
    ch1 = (64'(p.infrared) * scale) >> 10;
    ratio = 0;
    if (ch0 != 0) ratio = (ch1 << 10) / ch0;
    ratio = (ratio + 1) >> 1;
    // first breakpoint at or above the ratio; past the last one both stay zero
    for (int i = 6; i >= 0; i--) begin
      if (pkg_kind == lcalc_pkg::PKG_CS) begin
        if (ratio <= 64'(BRK_CS_TB[i])) begin
          off   = 64'(OFF_CS_TB[i]);
          slope = 64'(SLP_CS_TB[i]);
        end
      end else begin
        if (ratio <= 64'(BRK_T_TB[i])) begin
          off   = 64'(OFF_T_TB[i]);
          slope = 64'(SLP_T_TB[i]);
        end
      end
    end
    pos  = ch0 * off;
    neg  = ch1 * slope;
    diff = (pos > neg) ? pos - neg : 64'd0;
    diff = (diff + 64'd8192) >> 14;
    return diff[20:0];
  endfunction

  function automatic logic hold_off();
    return !steady && ($urandom_range(0, 99) < 8);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // Register write driven after the next edge; the mirror follows the block's masking rules
  task automatic write_reg(logic [lcalc_pkg::CFG_IDX_W-1:0] idx,
                           logic [lcalc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      lcalc_pkg::CFG_ITIME: itime_sel = data;
      lcalc_pkg::CFG_GAIN:  gain_hi   = data[0];
      lcalc_pkg::CFG_PKG:   pkg_kind  = data[0];
      default: ;
    endcase
  endtask

  task automatic push_pair(int bb, int ir);
    count_pair_t p;
    p.broadband = 16'(bb);
    p.infrared  = 16'(ir);
    pair_queue.push_back(p);
  endtask

  // Count pairs biased to spread the ratio over every segment
  task automatic push_random_pair();
    int bb, ir, kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      bb = $urandom_range(0, (1 << $urandom_range(1, 16)) - 1);
      ir = (bb * $urandom_range(0, 800)) / 512;
      if (ir > 65535) ir = 65535;
    end else if (kind <= 7) begin
      bb = $urandom_range(0, 65535);
      ir = $urandom_range(0, 65535);
    end else if (kind == 8) begin
      bb = $urandom_range(0, 15);
      ir = $urandom_range(0, 15);
    end else begin
      bb = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 1);
      ir = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 1);
    end
    push_pair(bb, ir);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pair_queue.size() != 0 || s_tvalid || lux_expected.size() != 0);
  endtask

  // Request driver: holds a request until taken, idles at random between requests
  always @(posedge clk) begin
    count_pair_t nxt;
    logic        take;
    take = s_tvalid && s_tready;
    if (take) lux_expected.push_back(lux_predict(count_pair_t'(s_tdata)));
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !take) begin
      s_tvalid <= 1'b1;
    end else if (pair_queue.size() != 0 && !hold_off()) begin
      nxt = pair_queue.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= nxt;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Result monitor and random back-pressure
  always @(posedge clk) begin
    logic [20:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (lux_expected.size() == 0) begin
        report_mismatch("unexpected lux_value", int'(m_tdata[20:0]), -1);
      end else begin
        want = lux_expected.pop_front();
        if (m_tdata[20:0] !== want) report_mismatch("lux_value", int'(m_tdata[20:0]), int'(want));
        if (m_tdata[23:21] !== 3'b000) report_mismatch("pad bits", int'(m_tdata[23:21]), 0);
      end
    end
    m_tready <= !hold_off();
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    static int ratios[10] = '{'h040, 'h041, 'h080, 'h081, 'h0c0, 'h100, 'h138, 'h19a,
                             'h29a, 'h29b};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, zero broadband, every segment edge, ratio past the table
    push_pair(0, 0);
    push_pair(65535, 65535);
    push_pair(65535, 0);
    push_pair(0, 65535);
    push_pair(1, 0);
    push_pair(1, 1);
    push_pair(0, 1);
    push_pair(100, 200);
    push_pair(43690, 21845);
    foreach (ratios[i]) push_pair(1000, (1000 * ratios[i]) / 512);
    push_pair(65535, (65535 * 'h29a) / 512 > 65535 ? 65535 : (65535 * 'h29a) / 512);
    repeat (40) push_random_pair();
    wait_drained();

    for (int ph = 0; ph < PHASE_N; ph++) begin
      write_reg(lcalc_pkg::CFG_ITIME, PH_ITIME[ph]);
      write_reg(lcalc_pkg::CFG_GAIN,  PH_GAIN[ph]);
      write_reg(lcalc_pkg::CFG_PKG,   PH_PKG[ph]);
      // an out-of-range index must leave every register alone
      if (ph == PHASE_N - 1) write_reg(CFG_UNUSED, 2'd3);
      @(posedge clk);
      cfg_we <= 1'b0;
      steady <= (ph == 3);
      push_pair(65535, 65535);
      push_pair(0, 0);
      repeat (RAND_ITEMS) push_random_pair();
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
